[rtl/core/bc1_pkg.sv]
// bc1_pkg: shared types, constants and color arithmetic for the bc1 block decoder
// used by bc1_front, bc1_queue, bc1_back and bc1_block_decoder; no dependencies

package bc1_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int PIXEL_CNT_W = 4;
	localparam logic [PIXEL_CNT_W-1:0] LAST_PIXEL_CNT = 4'd15;
	localparam logic [1:0] TRANSPARENT_SEL = 2'd3;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR = 8'h00;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	typedef struct packed {
		color_t [3:0] pal;
		logic three_color;
		logic [31:0] index_word;
	} block_t;

	// x*255/31 truncated, as 8x + floor(7x/31)
	function automatic logic [7:0] expand5(input logic [4:0] x);
		logic [7:0] t;
		logic [12:0] p;
		t = 8'({3'b000, x} * 8'd7) + 8'd1;
		p = 13'(t) * 13'd33;
		return {x, 3'b000} + {5'b00000, p[12:10]};
	endfunction

	// x*255/63 truncated, as 4x + floor(x/21)
	function automatic logic [7:0] expand6(input logic [5:0] x);
		logic [1:0] q;
		if (x >= 6'd63) begin
			q = 2'd3;
		end else if (x >= 6'd42) begin
			q = 2'd2;
		end else if (x >= 6'd21) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return {x, 2'b00} + {6'b000000, q};
	endfunction

	function automatic color_t expand565(input logic [15:0] c);
		color_t e;
		e.r = expand5(c[15:11]);
		e.g = expand6(c[10:5]);
		e.b = expand5(c[4:0]);
		return e;
	endfunction

	// floor(s/3) for s up to 765
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = 20'(s) * 20'd683;
		return 8'(p[19:11]);
	endfunction

	function automatic logic [7:0] third(input logic [7:0] near, input logic [7:0] far);
		logic [9:0] s;
		s = {1'b0, near, 1'b0} + {2'b00, far};
		return div3(s);
	endfunction

	function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

endpackage

[rtl/core/bc1_front.sv]
// bc1_front: accepts blocks, expands endpoints and builds the four-entry palette
// two pipeline stages feeding the queue; depends on bc1_pkg

module bc1_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           endpoint_a,
	input  logic [15:0]           endpoint_b,
	input  logic [31:0]           index_word,
	output logic                  push,
	output bc1_pkg::block_t       push_blk,
	input  logic                  queue_full
);

	logic valid_s1;
	logic valid_s2;
	bc1_pkg::color_t ea_s1;
	bc1_pkg::color_t eb_s1;
	logic three_s1;
	logic [31:0] idx_s1;
	bc1_pkg::block_t blk_s2;
	bc1_pkg::block_t blk_next;
	logic ready_s1;
	logic ready_s2;
	logic take;

	assign ready_s2 = !valid_s2 || !queue_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign take = in_valid && ready_s1;

	assign push = valid_s2 && !queue_full;
	assign push_blk = blk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ea_s1 <= bc1_pkg::expand565(endpoint_a);
			eb_s1 <= bc1_pkg::expand565(endpoint_b);
			three_s1 <= !(endpoint_a > endpoint_b);
			idx_s1 <= index_word;
		end
		if (ready_s2 && valid_s1) begin
			blk_s2 <= blk_next;
		end
	end

	always_comb begin
		blk_next.pal[0] = ea_s1;
		blk_next.pal[1] = eb_s1;
		blk_next.three_color = three_s1;
		blk_next.index_word = idx_s1;
		if (three_s1) begin
			blk_next.pal[2].r = bc1_pkg::half(ea_s1.r, eb_s1.r);
			blk_next.pal[2].g = bc1_pkg::half(ea_s1.g, eb_s1.g);
			blk_next.pal[2].b = bc1_pkg::half(ea_s1.b, eb_s1.b);
			blk_next.pal[3] = '0;
		end else begin
			blk_next.pal[2].r = bc1_pkg::third(ea_s1.r, eb_s1.r);
			blk_next.pal[2].g = bc1_pkg::third(ea_s1.g, eb_s1.g);
			blk_next.pal[2].b = bc1_pkg::third(ea_s1.b, eb_s1.b);
			blk_next.pal[3].r = bc1_pkg::third(eb_s1.r, ea_s1.r);
			blk_next.pal[3].g = bc1_pkg::third(eb_s1.g, ea_s1.g);
			blk_next.pal[3].b = bc1_pkg::third(eb_s1.b, ea_s1.b);
		end
	end

endmodule

[rtl/core/bc1_queue.sv]
// bc1_queue: small fifo of decoded palettes between front and back
// depends on bc1_pkg

module bc1_queue #(
	parameter int DEPTH = bc1_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bc1_pkg::block_t push_blk,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output bc1_pkg::block_t head_blk
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bc1_pkg::block_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_blk = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_blk;
		end
	end

endmodule

[rtl/core/bc1_back.sv]
// bc1_back: walks the 16 pixels of the head block, one per transfer
// selects the palette entry per pixel and holds the output register; depends on bc1_pkg

module bc1_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  bc1_pkg::block_t head_blk,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      pixel_col,
	output logic [1:0]      pixel_row,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic [7:0]      alpha,
	output logic            last_pixel
);

	logic [bc1_pkg::PIXEL_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic advance;
	logic fire;
	logic [1:0] sel;
	logic clear;
	bc1_pkg::color_t color;

	assign advance = !out_valid_q || !out_stall;
	assign fire = advance && head_valid;
	assign pop = fire && (cnt_q == bc1_pkg::LAST_PIXEL_CNT);
	assign out_valid = out_valid_q;

	assign sel = head_blk.index_word[{cnt_q, 1'b0} +: 2];
	assign clear = head_blk.three_color && (sel == bc1_pkg::TRANSPARENT_SEL);
	assign color = head_blk.pal[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_col <= cnt_q[1:0];
			pixel_row <= cnt_q[3:2];
			red <= color.r;
			green <= color.g;
			blue <= color.b;
			alpha <= clear ? bc1_pkg::ALPHA_CLEAR : bc1_pkg::ALPHA_OPAQUE;
			last_pixel <= (cnt_q == bc1_pkg::LAST_PIXEL_CNT);
		end
	end

endmodule

[rtl/core/bc1_block_decoder.sv]
// bc1_block_decoder: top level of the bc1 (dxt1) block decoder
// instantiates bc1_front, bc1_queue and bc1_back; depends on bc1_pkg
//
// Each accepted block (two rgb565 endpoints and 32 index bits) yields 16 rgba pixels, row by
// row with the column inner, one pixel per output transfer, last_pixel marking the sixteenth.
// The single output register presents one pixel per cycle while out_stall is low and a block
// waits in the queue. After its input transfer a block passes the second palette stage, the
// queue write and the output register, in that order, before its first pixel is presented. Up
// to DEPTH decoded blocks wait in the queue, so the input side keeps taking blocks while the
// output side is stalled, until the queue and both front stages are full.

module bc1_block_decoder #(
	parameter int DEPTH = bc1_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] endpoint_a,
	input  logic [15:0] endpoint_b,
	input  logic [31:0] index_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  pixel_col,
	output logic [1:0]  pixel_row,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel
);

	logic push;
	logic full;
	logic pop;
	logic head_valid;
	bc1_pkg::block_t push_blk;
	bc1_pkg::block_t head_blk;

	bc1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.endpoint_a (endpoint_a),
		.endpoint_b (endpoint_b),
		.index_word (index_word),
		.push       (push),
		.push_blk   (push_blk),
		.queue_full (full)
	);

	bc1_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_blk   (push_blk),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_blk   (head_blk)
	);

	bc1_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_blk   (head_blk),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

endmodule

[tb/bc1_block_decoder_tb.sv]
// bc1_block_decoder_tb: self-checking testbench for the bc1 (dxt1) block decoder
// drives blocks with random gaps and stalls, predicts all 16 pixels per block and checks them
// depends on bc1_pkg and bc1_block_decoder
`timescale 1ns / 100ps

module bc1_block_decoder_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BLOCKS = 450;

	typedef struct packed {
		logic [1:0] col;
		logic [1:0] row;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} pixel_t;

	class bc1_pixel_board;
		pixel_t pixels_due[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// palette from the two endpoints, then one pixel per 2-bit index
		function void decode_block(input logic [15:0] ca, input logic [15:0] cb,
				input logic [31:0] idx);
			int shade [4][3];
			int opacity [4];
			int ch;
			int n;
			logic [1:0] sel;
			pixel_t px;
			shade[0][0] = int'(ca[15:11]) * 255 / 31;
			shade[0][1] = int'(ca[10:5]) * 255 / 63;
			shade[0][2] = int'(ca[4:0]) * 255 / 31;
			shade[1][0] = int'(cb[15:11]) * 255 / 31;
			shade[1][1] = int'(cb[10:5]) * 255 / 63;
			shade[1][2] = int'(cb[4:0]) * 255 / 31;
			for (n = 0; n < 4; n++) begin
				opacity[n] = int'(bc1_pkg::ALPHA_OPAQUE);
			end
			if (ca > cb) begin
				for (ch = 0; ch < 3; ch++) begin
					shade[2][ch] = (2 * shade[0][ch] + shade[1][ch]) / 3;
					shade[3][ch] = (shade[0][ch] + 2 * shade[1][ch]) / 3;
				end
			end else begin
				for (ch = 0; ch < 3; ch++) begin
					shade[2][ch] = (shade[0][ch] + shade[1][ch]) / 2;
					shade[bc1_pkg::TRANSPARENT_SEL][ch] = 0;
				end
				opacity[bc1_pkg::TRANSPARENT_SEL] = int'(bc1_pkg::ALPHA_CLEAR);
			end
			for (n = 0; n < 16; n++) begin
				sel = idx[8 * (n / 4) + 2 * (n % 4) +: 2];
				px.col = 2'(n % 4);
				px.row = 2'(n / 4);
				px.r = 8'(shade[sel][0]);
				px.g = 8'(shade[sel][1]);
				px.b = 8'(shade[sel][2]);
				px.a = 8'(opacity[sel]);
				px.last = (n == 15);
				pixels_due.push_back(px);
			end
		endfunction

		task check_pixel(input pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				report($sformatf("unexpected pixel row %0d col %0d", got.row, got.col));
				return;
			end
			want = pixels_due.pop_front();
			if (got.col !== want.col)
				report($sformatf("pixel_col got %0d want %0d", got.col, want.col));
			if (got.row !== want.row)
				report($sformatf("pixel_row got %0d want %0d", got.row, want.row));
			if (got.r !== want.r)
				report($sformatf("red got %0d want %0d", got.r, want.r));
			if (got.g !== want.g)
				report($sformatf("green got %0d want %0d", got.g, want.g));
			if (got.b !== want.b)
				report($sformatf("blue got %0d want %0d", got.b, want.b));
			if (got.a !== want.a)
				report($sformatf("alpha got %0d want %0d", got.a, want.a));
			if (got.last !== want.last)
				report($sformatf("last_pixel got %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] endpoint_a = '0;
	logic [15:0] endpoint_b = '0;
	logic [31:0] index_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  pixel_col;
	logic [1:0]  pixel_row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last_pixel;

	bit calm = 1'b0;
	int cycle_count = 0;
	bc1_pixel_board board;

	bc1_block_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.endpoint_a (endpoint_a),
		.endpoint_b (endpoint_b),
		.index_word (index_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_pixel (last_pixel)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 30);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_pixel({pixel_col, pixel_row, red, green, blue, alpha, last_pixel});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_block(input logic [15:0] ca, input logic [15:0] cb,
			input logic [31:0] idx);
		while (!calm && $urandom_range(99) < 30) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		endpoint_a <= ca;
		endpoint_b <= cb;
		index_word <= idx;
		do @(posedge clk); while (in_stall);
		board.decode_block(ca, cb, idx);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// rgb565 with each channel at zero or full scale
	function automatic logic [15:0] corner565(input int pick);
		return {pick[0] ? 5'h1F : 5'h00, pick[1] ? 6'h3F : 6'h00, pick[2] ? 5'h1F : 5'h00};
	endfunction

	task automatic run_random(input int count);
		int i;
		int kind;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] t;
		logic [31:0] idx;
		for (i = 0; i < count; i++) begin
			ca = 16'($urandom);
			cb = 16'($urandom);
			idx = $urandom;
			kind = $urandom_range(9);
			case (kind)
				0: begin
					cb = ca;
				end
				1: begin
					ca = corner565($urandom_range(7));
					cb = corner565($urandom_range(7));
				end
				2, 3: begin
					if (ca < cb) begin
						t = ca;
						ca = cb;
						cb = t;
					end
				end
				default: begin
				end
			endcase
			send_block(ca, cb, idx);
		end
	endtask

	initial begin
		board = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
		send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
		send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_block(16'h0000, 16'h0000, 32'h0000_0000);
		send_block(16'h0001, 16'h0000, 32'h1B1B_1B1B);
		send_block(16'hF800, 16'h07E0, 32'h39C6_E41B);
		send_block(16'h07E0, 16'hF800, 32'hFFFF_0000);
		send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
		send_block(16'h07E0, 16'h001F, 32'h5555_5555);
		send_block(16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF);
		send_block(16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF);
		send_block(16'h8000, 16'h7FFF, 32'h0123_4567);
		send_block(16'h7FFF, 16'h8000, 32'hFEDC_BA98);
		send_block(16'h1234, 16'h1234, 32'hC3C3_3C3C);
		drain();

		run_random(150);
		calm = 1'b1;
		run_random(100);
		calm = 1'b0;
		drain();
		run_random(RANDOM_BLOCKS - 250);
		drain();
		repeat (20) @(posedge clk);

		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
